/* rtl/core/assert_macros.svh */
// Shared assertion helpers for the line stepper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BLS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bls assertion failed");

// Next-cycle implication, disabled while reset is held.
`define BLS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bls assertion failed");

`endif

/* rtl/core/bls_pkg.sv */
`default_nettype none

package bls_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int DIM_BITS       = 12;
    localparam int COLOR_BITS     = 32;
    localparam int ADDR_BITS      = 22;
    localparam int QUEUE_DEPTH    = 4;
    localparam int CFG_IDX_BITS   = 1;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 12'd480;

endpackage

`default_nettype wire

/* rtl/core/bls_front.sv */
`default_nettype none
`include "assert_macros.svh"

module bls_front #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_req_type,
    input  logic [COORD_BITS-1:0]          i_start_x,
    input  logic [COORD_BITS-1:0]          i_start_y,
    input  logic [COORD_BITS-1:0]          i_end_x,
    input  logic [COORD_BITS-1:0]          i_end_y,
    input  logic [bls_pkg::COLOR_BITS-1:0] i_line_color,
    input  logic                           i_q_full,
    output logic                           o_push,
    output logic [COORD_BITS-1:0]          o_pix_x,
    output logic [COORD_BITS-1:0]          o_pix_y,
    output logic [bls_pkg::COLOR_BITS-1:0] o_pix_color,
    output logic                           o_last
);
    import bls_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 2;
    localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

    logic [COORD_BITS-1:0] r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic [COORD_BITS-1:0] n_cur_x, n_cur_y, n_tgt_x, n_tgt_y;
    logic signed [DW-1:0]  r_dx, r_dyn, n_dx, n_dyn;
    logic signed [EW-1:0]  r_err, n_err;
    logic                  r_sxn, r_syn, n_sxn, n_syn;
    logic [COLOR_BITS-1:0] r_color, n_color;
    logic                  r_active, n_active;

    logic                  accept;
    logic                  last;
    logic signed [DW-1:0]  dxa, dya, s_dx, s_dyn;
    logic signed [EW:0]    e2, dyn_e, dx_e;
    logic                  go_x, go_y;
    logic signed [EW-1:0]  add_x, add_y;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    assign dxa   = $signed({i_end_x[COORD_BITS-1], i_end_x})
                 - $signed({i_start_x[COORD_BITS-1], i_start_x});
    assign dya   = $signed({i_end_y[COORD_BITS-1], i_end_y})
                 - $signed({i_start_y[COORD_BITS-1], i_start_y});
    assign s_dx  = dxa[DW-1] ? -dxa : dxa;
    assign s_dyn = dya[DW-1] ? dya : -dya;

    // doubled error against -|dy| and |dx|
    assign e2    = $signed({r_err, 1'b0});
    assign dyn_e = $signed({{2{r_dyn[DW-1]}}, r_dyn});
    assign dx_e  = $signed({{2{r_dx[DW-1]}}, r_dx});
    assign go_x  = e2 >= dyn_e;
    assign go_y  = e2 <= dx_e;
    assign add_x = go_x ? $signed({r_dyn[DW-1], r_dyn}) : '0;
    assign add_y = go_y ? $signed({r_dx[DW-1], r_dx}) : '0;

    always_comb begin
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_tgt_x  = r_tgt_x;
        n_tgt_y  = r_tgt_y;
        n_dx     = r_dx;
        n_dyn    = r_dyn;
        n_sxn    = r_sxn;
        n_syn    = r_syn;
        n_err    = r_err;
        n_color  = r_color;
        n_active = r_active;
        o_push   = 1'b0;
        if (accept) begin
            if (i_req_type == REQ_START) begin
                n_cur_x = i_start_x;
                n_cur_y = i_start_y;
                n_tgt_x = i_end_x;
                n_tgt_y = i_end_y;
                n_dx    = s_dx;
                n_dyn   = s_dyn;
                n_sxn   = dxa[DW-1] || (dxa == '0);
                n_syn   = dya[DW-1] || (dya == '0);
                n_err   = $signed({s_dx[DW-1], s_dx}) + $signed({s_dyn[DW-1], s_dyn});
                n_color = i_line_color;
                o_push  = 1'b1;
            end else if (r_active) begin
                if (go_x) begin
                    n_cur_x = r_sxn ? r_cur_x - ONE : r_cur_x + ONE;
                end
                if (go_y) begin
                    n_cur_y = r_syn ? r_cur_y - ONE : r_cur_y + ONE;
                end
                n_err  = r_err + add_x + add_y;
                o_push = 1'b1;
            end
        end
        last = (n_cur_x == n_tgt_x) && (n_cur_y == n_tgt_y);
        if (o_push) begin
            n_active = !last;
        end
    end

    assign o_pix_x     = n_cur_x;
    assign o_pix_y     = n_cur_y;
    assign o_pix_color = n_color;
    assign o_last      = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x <= n_cur_x;
        r_cur_y <= n_cur_y;
        r_tgt_x <= n_tgt_x;
        r_tgt_y <= n_tgt_y;
        r_dx    <= n_dx;
        r_dyn   <= n_dyn;
        r_sxn   <= n_sxn;
        r_syn   <= n_syn;
        r_err   <= n_err;
        r_color <= n_color;
    end

    `BLS_ASSERT_IMP(a_idle_step, i_clk, i_rst_n, !r_active && (i_req_type == REQ_STEP), !o_push)
    `BLS_ASSERT_NXT(a_last_ends_line, i_clk, i_rst_n, o_push && o_last, !r_active)

endmodule

`default_nettype wire

/* rtl/core/bls_queue.sv */
`default_nettype none
`include "assert_macros.svh"

module bls_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import bls_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             do_pop;

    assign o_full  = r_count == FULL_CNT;
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `BLS_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `BLS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT)

endmodule

`default_nettype wire

/* rtl/core/bls_back.sv */
`default_nettype none

module bls_back #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [bls_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [bls_pkg::DIM_BITS-1:0]     i_cfg_data,
    input  logic                             i_q_valid,
    output logic                             o_pop,
    input  logic [COORD_BITS-1:0]            i_pix_x,
    input  logic [COORD_BITS-1:0]            i_pix_y,
    input  logic [bls_pkg::COLOR_BITS-1:0]   i_pix_color,
    input  logic                             i_last,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [COORD_BITS-1:0]            o_pix_x,
    output logic [COORD_BITS-1:0]            o_pix_y,
    output logic [bls_pkg::COLOR_BITS-1:0]   o_pix_color,
    output logic [bls_pkg::ADDR_BITS-1:0]    o_pix_address,
    output logic                             o_on_screen,
    output logic                             o_last
);
    import bls_pkg::*;

    localparam int CW = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
    localparam int MW = COORD_BITS + DIM_BITS;
    localparam int SW = (MW > ADDR_BITS) ? MW : ADDR_BITS;

    logic [DIM_BITS-1:0]   r_width, r_height;

    logic                  r_s1_v;
    logic [COORD_BITS-1:0] r_s1_x, r_s1_y;
    logic [COLOR_BITS-1:0] r_s1_color;
    logic                  r_s1_last, r_s1_on;
    logic [MW-1:0]         r_s1_prod;

    logic                  r_s2_v;
    logic [COORD_BITS-1:0] r_s2_x, r_s2_y;
    logic [COLOR_BITS-1:0] r_s2_color;
    logic                  r_s2_last, r_s2_on;
    logic [ADDR_BITS-1:0]  r_s2_addr;

    logic                  s1_ready, s2_ready;
    logic                  on;
    logic [SW-1:0]         sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                REG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s2_ready = !r_s2_v || i_ready;
    assign s1_ready = !r_s1_v || s2_ready;
    assign o_pop    = i_q_valid && s1_ready;

    assign on = !i_pix_x[COORD_BITS-1] && !i_pix_y[COORD_BITS-1]
             && (CW'(i_pix_x) < CW'(r_width)) && (CW'(i_pix_y) < CW'(r_height));

    assign sum = SW'(r_s1_prod) + SW'(r_s1_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_v <= i_q_valid;
            end
            if (s2_ready) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_x     <= i_pix_x;
            r_s1_y     <= i_pix_y;
            r_s1_color <= i_pix_color;
            r_s1_last  <= i_last;
            r_s1_on    <= on;
            r_s1_prod  <= MW'(i_pix_y) * MW'(r_width);
        end
        if (r_s1_v && s2_ready) begin
            r_s2_x     <= r_s1_x;
            r_s2_y     <= r_s1_y;
            r_s2_color <= r_s1_color;
            r_s2_last  <= r_s1_last;
            r_s2_on    <= r_s1_on;
            r_s2_addr  <= r_s1_on ? sum[ADDR_BITS-1:0] : '0;
        end
    end

    assign o_valid       = r_s2_v;
    assign o_pix_x       = r_s2_x;
    assign o_pix_y       = r_s2_y;
    assign o_pix_color   = r_s2_color;
    assign o_pix_address = r_s2_addr;
    assign o_on_screen   = r_s2_on;
    assign o_last        = r_s2_last;

endmodule

`default_nettype wire

/* rtl/core/bresenham_line_stepper.sv */
// Bresenham line stepper, all octants, one pixel per transfer.
// Input stream (s_axis): tuser = 0 starts a line from the endpoints in tdata
// and emits its first pixel; tuser = 1 emits the next pixel of the active line.
// A step with no active line is consumed and gives no pixel.
// Output stream (m_axis): one pixel with coordinates, color and frame-buffer
// address x + y * width; tuser flags the pixel on screen (address is 0 when
// not), tlast marks the line's final endpoint.
// Config channel: index 0 = screen width, 1 = screen height; write only while
// the block is idle. o_cfg_ready is always high.
// Throughput: one input transfer per cycle while the queue is not full. The
// pixel is registered in the 4-entry queue, then in the multiply and
// address-add stages, before o_m_axis_tvalid rises.
// When the receiver stalls, the queue and pipeline fill and s_axis tready
// drops once the queue is full; nothing is lost.
// Reset (synchronous, active low) clears the active line, empties the queue
// and pipeline stages, and restores width 640, height 480.
`default_nettype none

module bresenham_line_stepper #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF,
    localparam int IN_W  = ((4 * COORD_BITS + bls_pkg::COLOR_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + bls_pkg::COLOR_BITS
                            + bls_pkg::ADDR_BITS + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // start_x, start_y, end_x_in, end_y_in, line_color
    input  logic [IN_W-1:0]                  i_s_axis_tdata,
    // req_type
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // pix_x, pix_y, pix_color, pix_address
    output logic [OUT_W-1:0]                 o_m_axis_tdata,
    // on_screen
    output logic                             o_m_axis_tuser,
    output logic                             o_m_axis_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bls_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [bls_pkg::DIM_BITS-1:0]     i_cfg_data
);
    import bls_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int QW = 2 * C + COLOR_BITS + 1;

    logic                  push, q_full, q_valid, pop;
    logic [C-1:0]          f_x, f_y, b_x, b_y;
    logic [COLOR_BITS-1:0] f_color, b_color;
    logic                  f_last;
    logic [QW-1:0]         q_out;
    logic [ADDR_BITS-1:0]  b_addr;

    assign o_cfg_ready = 1'b1;

    bls_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_req_type   (i_s_axis_tuser),
        .i_start_x    (i_s_axis_tdata[C-1:0]),
        .i_start_y    (i_s_axis_tdata[2*C-1:C]),
        .i_end_x      (i_s_axis_tdata[3*C-1:2*C]),
        .i_end_y      (i_s_axis_tdata[4*C-1:3*C]),
        .i_line_color (i_s_axis_tdata[4*C+COLOR_BITS-1:4*C]),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_pix_x      (f_x),
        .o_pix_y      (f_y),
        .o_pix_color  (f_color),
        .o_last       (f_last)
    );

    bls_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_last, f_color, f_y, f_x}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    bls_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_valid     (q_valid),
        .o_pop         (pop),
        .i_pix_x       (q_out[C-1:0]),
        .i_pix_y       (q_out[2*C-1:C]),
        .i_pix_color   (q_out[2*C+COLOR_BITS-1:2*C]),
        .i_last        (q_out[QW-1]),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_pix_x       (b_x),
        .o_pix_y       (b_y),
        .o_pix_color   (b_color),
        .o_pix_address (b_addr),
        .o_on_screen   (o_m_axis_tuser),
        .o_last        (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = OUT_W'({b_addr, b_color, b_y, b_x});

endmodule

`default_nettype wire
